// ===== sv/sdlm_pkg.sv =====
// Shared types and constants for the batch weight update core.
`default_nettype none
package sdlm_pkg;
    localparam int IDX_W = 12;
    localparam int SUM_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MU = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH = 3'd4;
    localparam logic [16:0] GAMMA_ONE = 17'd65536;

    typedef struct packed {
        logic [IDX_W-1:0]  element_index;
        logic signed [31:0] gradient;
        logic signed [31:0] hessian;
        logic               first_sample;
        logic               last_sample;
        logic signed [31:0] weight_in;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  updated_index;
        logic signed [31:0] weight_out;
        logic               divisor_zero;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_item;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        logic signed [31:0] r;
        if (v > 96'sd2147483647) r = 32'sh7fffffff;
        else if (v < -96'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== sv/sdlm_if.sv =====
// Valid/ready channel interfaces for items and configuration writes.
`default_nettype none
interface sdlm_in_if;
    logic valid;
    logic ready;
    sdlm_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdlm_out_if;
    logic valid;
    logic ready;
    sdlm_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdlm_cfg_if;
    logic valid;
    logic ready;
    sdlm_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sdlm_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module sdlm_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [63:0] i_den,
    output logic                    o_done,
    output logic signed [63:0]      o_quo
);
    import sdlm_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [63:0] r_den;
    logic [64:0] r_rem;
    logic        r_neg;
    logic [64:0] n_rem;
    logic [64:0] n_trial;

    // Shift in one numerator bit and try a subtract.
    always_comb begin
        n_rem   = {r_rem[63:0], r_q[63]};
        n_trial = n_rem - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[63] ? 64'(-i_num) : i_num;
            r_den <= i_den[63] ? 64'(-i_den) : i_den;
            r_neg <= i_num[63] ^ i_den[63];
            r_rem <= '0;
        end else if (r_busy) begin
            if (!n_trial[64]) begin
                r_rem <= n_trial;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_quo = r_neg ? 64'(-r_q) : r_q;
endmodule
`default_nettype wire

// ===== sv/sdlm_batch_weight_update_core.sv =====
// Batch weight update core: per-element sums in memory, update on the last sample.
// Flow: a sample that is not last is read, modified and written back, then frees the input.
// A last sample then takes three divides on one shared bit-serial divider before its result
// shows; plain mode skips the blend and the step divide, a zero divisor skips the step divide.
// Reset: synchronous active low; registers return to defaults, then the history is cleared entry by entry.
`default_nettype none
module sdlm_batch_weight_update_core #(
    parameter int ELEMENTS  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sdlm_in_if.sink   i_item,
    sdlm_cfg_if.sink  i_cfg,
    sdlm_out_if.source o_result
);
    import sdlm_pkg::*;

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_ACC   = 10'b0000000100,
        S_GDIV  = 10'b0000001000,
        S_HDIV  = 10'b0000010000,
        S_BLEND = 10'b0000100000,
        S_STEP  = 10'b0001000000,
        S_SDIV  = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // Configuration registers.
    logic        r_mode;
    logic [30:0] r_lr;
    logic [16:0] r_gamma;
    logic [30:0] r_mu;
    logic [15:0] r_batch;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_lr    <= 31'd655;
            r_gamma <= 17'd6554;
            r_mu    <= 31'd1311;
            r_batch <= 16'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_MODE:  r_mode  <= i_cfg.data.data[0];
                REG_LR:    r_lr    <= i_cfg.data.data[30:0];
                REG_GAMMA: r_gamma <= i_cfg.data.data[16:0];
                REG_MU:    r_mu    <= i_cfg.data.data[30:0];
                REG_BATCH: r_batch <= i_cfg.data.data[15:0];
                default: ;
            endcase
        end
    end

    // Memories: both sums in one row, old Hessian with its history bit on top.
    logic [2*SUM_W-1:0] r_sum_mem [ELEMENTS];
    logic [32:0]        r_prev_mem [ELEMENTS];
    logic [2*SUM_W-1:0] r_sum_rd;
    logic signed [31:0] r_prev_rd;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    t_state   r_state;
    t_in_item r_item;
    logic [AW-1:0] w_addr;
    logic signed [SUM_W-1:0] r_gsum, r_hsum;
    logic signed [31:0] r_gavg, r_havg, r_blend;
    logic signed [63:0] r_prod, r_div;
    logic               r_hv_bit;
    logic               r_ovalid;
    t_out_item          r_out;

    // Divider shared by all three divisions.
    logic               div_start, div_done;
    logic signed [63:0] div_num, div_den, div_quo;
    sdlm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quo(div_quo)
    );

    logic in_range;
    logic in_accept;
    assign in_range = ({4'd0, i_item.data.element_index} < 16'(ELEMENTS))
        || (ELEMENTS > 4095);
    assign w_addr = AW'(r_item.element_index);
    assign i_item.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign in_accept = i_item.valid && (r_state == S_IDLE) && !r_clr_busy;

    logic signed [SUM_W-1:0] n_gsum, n_hsum;
    logic signed [63:0] bs;
    logic [16:0] gm;
    logic signed [63:0] n_blend_wide;
    logic signed [95:0] n_w;
    logic signed [63:0] n_prod, n_div;

    always_comb begin
        n_gsum = r_item.first_sample ? SUM_W'(r_item.gradient)
            : r_sum_rd[2*SUM_W-1:SUM_W] + SUM_W'(r_item.gradient);
        n_hsum = r_item.first_sample ? SUM_W'(r_item.hessian)
            : r_sum_rd[SUM_W-1:0] + SUM_W'(r_item.hessian);
        bs = (r_batch == 16'd0) ? 64'sd1 : $signed({48'd0, r_batch});
        gm = (r_gamma > GAMMA_ONE) ? GAMMA_ONE : r_gamma;
        n_blend_wide = $signed({47'd0, 17'(GAMMA_ONE - gm)}) * 64'(r_prev_rd)
            + $signed({47'd0, gm}) * 64'(r_havg);
        n_w = 96'(r_item.weight_in) + 96'(div_quo);
        n_prod = $signed({33'd0, r_lr}) * 64'(r_gavg);
        n_div  = 64'(r_blend) + $signed({33'd0, r_mu});
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = 64'(r_gsum);
        div_den   = bs;
        unique case (r_state)
            S_ACC: begin
                div_start = r_item.last_sample;
                div_num   = 64'(n_gsum);
            end
            S_GDIV: begin
                div_start = div_done;
                div_num   = 64'(r_hsum);
            end
            S_STEP: begin
                div_start = r_mode && (n_div != 64'sd0);
                div_num   = n_prod;
                div_den   = n_div;
            end
            default: ;
        endcase
    end

    // Clear the history after reset, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(ELEMENTS - 1)) r_clr_busy <= 1'b0;
        end
    end

    // Sequence: read, accumulate and write back, then the update on a last sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            else if (o_result.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_accept && in_range) r_state <= S_READ;
                S_READ: r_state <= S_ACC;
                S_ACC:  r_state <= r_item.last_sample ? S_GDIV : S_IDLE;
                S_GDIV: if (div_done) r_state <= S_HDIV;
                S_HDIV: if (div_done) r_state <= r_mode ? S_BLEND : S_STEP;
                S_BLEND: r_state <= S_STEP;
                S_STEP: r_state <= S_SDIV;
                S_SDIV: if (!r_mode || r_div == 64'sd0 || div_done) r_state <= S_FIN;
                S_FIN:  if (!r_ovalid) r_state <= S_OUT;
                S_OUT:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath and memory ports.
    always_ff @(posedge i_clk) begin
        if (in_accept) r_item <= i_item.data;
        if (r_state == S_READ) begin
            r_sum_rd <= r_sum_mem[w_addr];
            {r_hv_bit, r_prev_rd} <= r_prev_mem[w_addr];
        end
        if (r_state == S_ACC) begin
            r_sum_mem[w_addr] <= {n_gsum, n_hsum};
            r_gsum <= n_gsum;
            r_hsum <= n_hsum;
        end
        if (r_state == S_GDIV && div_done) r_gavg <= sat32(96'(div_quo));
        if (r_state == S_HDIV && div_done) r_havg <= sat32(96'(div_quo));
        if (r_state == S_BLEND) begin
            r_blend <= r_hv_bit ? sat32(96'(n_blend_wide >>> 16)
                + 96'((n_blend_wide < 0 && n_blend_wide[15:0] != 16'd0) ? 1 : 0))
                : r_havg;
        end
        if (r_clr_busy) r_prev_mem[r_clr_addr] <= '0;
        else if (r_state == S_STEP && r_mode) r_prev_mem[w_addr] <= {1'b1, r_blend};
        if (r_state == S_STEP) begin
            r_prod <= n_prod;
            r_div  <= r_mode ? n_div : 64'sd1;
        end
        if (r_state == S_SDIV && !r_mode) begin
            r_prod <= (r_prod >>> FRAC_BITS)
                + 64'((r_prod < 0 && (r_prod & ((64'sd1 <<< FRAC_BITS) - 64'sd1)) != 0)
                ? 1 : 0);
        end
        if (r_state == S_FIN && !r_ovalid) begin
            r_out.updated_index <= r_item.element_index;
            if (r_mode && r_div == 64'sd0) begin
                r_out.weight_out   <= r_item.weight_in;
                r_out.divisor_zero <= 1'b1;
            end else begin
                r_out.weight_out   <= r_mode ? sat32(n_w)
                    : sat32(96'(r_item.weight_in) + 96'(r_prod));
                r_out.divisor_zero <= 1'b0;
            end
        end
    end

    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_out;
endmodule
`default_nettype wire

// ===== test/sdlm_batch_weight_update_core_tb.sv =====
// Self-checking testbench for the batch weight update core: directed and random batches.
`timescale 1ns / 100ps
`default_nettype none
module sdlm_batch_weight_update_core_tb;
    import sdlm_pkg::*;

    localparam int  NUM_ELEM    = 4096;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_WAIT  = 300;
    localparam int  HOLD_CYCLES = 3000;

    logic i_clk;
    logic i_rst_n;

    sdlm_in_if  item_ch ();
    sdlm_cfg_if cfg_ch ();
    sdlm_out_if res_ch ();

    sdlm_batch_weight_update_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_result(res_ch)
    );

    // Register shadow copy
    logic        sh_mode;
    logic [30:0] sh_lr;
    logic [16:0] sh_gamma;
    logic [30:0] sh_mu;
    logic [15:0] sh_batch;

    // Per-element shadow state
    logic [47:0]        grad_acc [NUM_ELEM];
    logic [47:0]        hess_acc [NUM_ELEM];
    logic signed [31:0] hess_hist [NUM_ELEM];
    logic               hist_ok [NUM_ELEM];
    logic               touched [NUM_ELEM];

    t_in_item  sample_q [$];
    t_out_item weight_q [$];

    int  cycles;
    int  mismatches;
    int  samples_taken;
    int  updates_seen;
    int  zero_div_seen;
    logic started;
    logic hold_req;
    logic hold_done;
    int  hold_cnt;

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Fold one accepted sample into the shadow state; queue the new weight on a last sample.
    function automatic void fold_sample(input t_in_item it);
        int        idx;
        longint    bs, g_avg, h_avg, gm, blend, div, step, w;
        logic      dz;
        t_out_item exp_w;
        idx  = int'(it.element_index);
        step = 0;
        dz   = 1'b0;
        grad_acc[idx] = (it.first_sample ? 48'd0 : grad_acc[idx])
                        + {{16{it.gradient[31]}}, it.gradient};
        hess_acc[idx] = (it.first_sample ? 48'd0 : hess_acc[idx])
                        + {{16{it.hessian[31]}}, it.hessian};
        if (!it.last_sample) return;
        bs    = (sh_batch == 16'd0) ? 1 : longint'(sh_batch);
        g_avg = clip32(longint'($signed(grad_acc[idx])) / bs);
        h_avg = clip32(longint'($signed(hess_acc[idx])) / bs);
        if (sh_mode) begin
            gm    = (sh_gamma > GAMMA_ONE) ? 65536 : longint'(sh_gamma);
            blend = h_avg;
            if (hist_ok[idx]) begin
                blend = (65536 - gm) * longint'(hess_hist[idx]) + gm * h_avg;
                blend = clip32(blend / 65536);
            end
            hess_hist[idx] = blend[31:0];
            hist_ok[idx]   = 1'b1;
            div = blend + longint'(sh_mu);
            if (div == 0) dz = 1'b1;
            else step = (longint'(sh_lr) * g_avg) / div;
        end else begin
            step = (longint'(sh_lr) * g_avg) / 65536;
        end
        w = longint'(it.weight_in);
        if (!dz) w = clip32(w + step);
        exp_w.updated_index = it.element_index;
        exp_w.weight_out    = w[31:0];
        exp_w.divisor_zero  = dz;
        weight_q.push_back(exp_w);
    endfunction

    // Input driver: offer queued samples, hold a beat until it is taken
    always @(posedge i_clk) begin
        logic idle;
        if (item_ch.valid && item_ch.ready) begin
            fold_sample(item_ch.data);
            void'(sample_q.pop_front());
            samples_taken++;
        end
        idle = (cycles > 30000 && cycles < 60000) ? 1'b0 : ($urandom_range(99) < 9);
        if (item_ch.valid && !item_ch.ready) begin
            item_ch.valid <= 1'b1;
        end else if (started && sample_q.size() > 0 && !idle) begin
            item_ch.valid <= 1'b1;
            item_ch.data  <= sample_q[0];
        end else begin
            item_ch.valid <= 1'b0;
        end
    end

    // Result monitor: compare each beat with the oldest expected weight, stall at random
    always @(posedge i_clk) begin
        t_out_item exp_w;
        logic      nready;
        if (res_ch.valid && res_ch.ready) begin
            updates_seen++;
            if (res_ch.data.divisor_zero) zero_div_seen++;
            if (weight_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: idx %0d weight %0d dz %0b",
                             res_ch.data.updated_index, res_ch.data.weight_out,
                             res_ch.data.divisor_zero);
            end else begin
                exp_w = weight_q.pop_front();
                if (res_ch.data.updated_index !== exp_w.updated_index ||
                    res_ch.data.weight_out !== exp_w.weight_out ||
                    res_ch.data.divisor_zero !== exp_w.divisor_zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx %0d w %0d dz %0b, got idx %0d w %0d dz %0b",
                                 exp_w.updated_index, exp_w.weight_out, exp_w.divisor_zero,
                                 res_ch.data.updated_index, res_ch.data.weight_out,
                                 res_ch.data.divisor_zero);
                end
            end
        end
        nready = (cycles > 30000 && cycles < 60000) ? 1'b1 : ($urandom_range(99) >= 9);
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            nready    = 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            nready   = 1'b0;
        end
        res_ch.ready <= nready;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sdlm_batch_weight_update_core_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_MODE:  sh_mode  = val[0];
            REG_LR:    sh_lr    = val[30:0];
            REG_GAMMA: sh_gamma = val[16:0];
            REG_MU:    sh_mu    = val[30:0];
            REG_BATCH: sh_batch = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic m, input logic [30:0] lr, input logic [16:0] g,
                            input logic [30:0] mu_v, input logic [15:0] bs);
        write_reg(REG_MODE, {31'd0, m});
        write_reg(REG_LR, {1'b0, lr});
        write_reg(REG_GAMMA, {15'd0, g});
        write_reg(REG_MU, {1'b0, mu_v});
        write_reg(REG_BATCH, {16'd0, bs});
    endtask

    // Wait until all samples are in and every expected weight has come, then let the core settle
    task automatic drain();
        @(posedge i_clk);
        while (sample_q.size() > 0 || item_ch.valid || weight_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(524288)) - 262144);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_sample(input int idx, input logic f, input logic l);
        t_in_item it;
        it.element_index = idx[IDX_W-1:0];
        it.gradient      = pick32();
        it.hessian       = pick32();
        it.first_sample  = f | ~touched[idx];
        it.last_sample   = l;
        it.weight_in     = pick32();
        touched[idx]     = 1'b1;
        sample_q.push_back(it);
    endtask

    task automatic push_fixed(input int idx, input logic f, input logic l,
                              input logic [31:0] g, input logic [31:0] h, input logic [31:0] w);
        t_in_item it;
        it.element_index = idx[IDX_W-1:0];
        it.gradient      = g;
        it.hessian       = h;
        it.first_sample  = f | ~touched[idx];
        it.last_sample   = l;
        it.weight_in     = w;
        touched[idx]     = 1'b1;
        sample_q.push_back(it);
    endtask

    // Mostly complete batches on a small element pool, some loose samples on top
    task automatic push_random(input int count);
        int n, e, len;
        n = 0;
        while (n < count) begin
            e = ($urandom_range(9) == 0) ? $urandom_range(NUM_ELEM - 1) : $urandom_range(15);
            if ($urandom_range(99) < 80) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) push_sample(e, k == 0, k == len - 1);
                n += len;
            end else begin
                push_sample(e, 1'($urandom_range(1)), 1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        res_ch.ready  = 1'b0;
        started       = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        hold_cnt      = 0;
        cycles        = 0;
        mismatches    = 0;
        samples_taken = 0;
        updates_seen  = 0;
        zero_div_seen = 0;
        sh_mode  = 1'b1;
        sh_lr    = 31'd655;
        sh_gamma = 17'd6554;
        sh_mu    = 31'd1311;
        sh_batch = 16'd1;
        for (int i = 0; i < NUM_ELEM; i++) begin
            grad_acc[i] = '0; hess_acc[i] = '0; hess_hist[i] = '0;
            hist_ok[i] = 1'b0; touched[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);
        started <= 1'b1;

        // Directed: extremes at reset settings, history reuse, multi-sample batch
        push_fixed(0, 1, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        push_fixed(1, 1, 1, 32'h80000000, 32'h80000000, 32'h80000000);
        push_fixed(0, 1, 1, 32'd0, 32'd0, 32'd0);
        push_fixed(2, 1, 0, 32'd123456, 32'd65536, 32'd0);
        push_fixed(2, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'd0);
        push_fixed(2, 0, 1, 32'h7fffffff, 32'd1, 32'h12345678);
        push_fixed(4095, 1, 1, $urandom, $urandom, $urandom);
        drain();

        // Zero divisor: no damping, full gamma, then gamma above one
        set_regs(1'b1, 31'h7fffffff, 17'd65536, 31'd0, 16'd0);
        push_fixed(3, 1, 1, 32'd65536, 32'd0, 32'h00010000);
        push_fixed(3, 1, 1, 32'd65536, 32'd0, 32'h00020000);
        push_fixed(5, 1, 1, 32'h80000000, 32'h00000001, 32'h7fffffff);
        drain();
        write_reg(REG_GAMMA, 32'h1ffff);
        write_reg(REG_MU, 32'd65536);
        push_fixed(3, 1, 1, 32'h7fffffff, 32'hffff0000, 32'd7);
        push_fixed(6, 1, 0, 32'd1000, 32'd2000, 32'd0);
        push_fixed(6, 0, 1, 32'd1000, 32'd2000, 32'd0);
        drain();

        // Plain step with largest rate and batch
        set_regs(1'b0, 31'h7fffffff, 17'd0, 31'h7fffffff, 16'hffff);
        push_fixed(7, 1, 1, 32'h7fffffff, 32'd5, 32'h7fffffff);
        push_fixed(8, 1, 1, 32'h80000000, 32'd5, 32'h80000000);
        push_fixed(9, 1, 0, 32'h7fffffff, 32'd1, 32'd0);
        push_fixed(9, 0, 1, 32'h7fffffff, 32'd1, 32'd0);
        drain();
        write_reg(REG_BATCH, 32'd1);
        push_fixed(10, 1, 1, 32'h7fffffff, 32'd0, 32'h7fffffff);
        push_fixed(10, 1, 1, 32'h80000000, 32'd0, 32'h80000000);
        drain();

        // Random phases, each under fresh settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(1'b1, 31'd655, 17'd6554, 31'd1311, 16'd1);
                1: set_regs(1'b1, 31'd0, 17'd0, 31'h7fffffff, 16'd2);
                2: set_regs(1'b0, 31'($urandom), 17'($urandom_range(131071)),
                            31'($urandom), 16'd0);
                default: set_regs(1'($urandom_range(1)), 31'($urandom),
                                  17'($urandom_range(131071)),
                                  31'($urandom_range(1) ? $urandom_range(65536) : $urandom),
                                  16'($urandom_range(1, 6)));
            endcase
            if (ph == 3) hold_req <= 1'b1;
            push_random(150);
            drain();
        end

        $display("covered %0d samples and %0d weight updates (%0d with zero divisor)",
                 samples_taken, updates_seen, zero_div_seen);
        $display("over both step modes, extreme registers, full stalls and %0d cycles", cycles);
        if (mismatches == 0) begin
            $display("sdlm_batch_weight_update_core_tb passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("sdlm_batch_weight_update_core_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/sdlm_pkg.sv
sv/sdlm_if.sv
sv/sdlm_div.sv
sv/sdlm_batch_weight_update_core.sv
test/sdlm_batch_weight_update_core_tb.sv
